// ----- rtl/core/utnw_pkg.sv -----
// shared types and constants of the utf-8 whitespace normalizer
`timescale 1ns / 1ps

package utnw_pkg;

  // counter and limit widths
  localparam int unsigned CntW    = 16;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // most bytes one input beat can produce: a space and a 4-byte character
  localparam int unsigned RunBytes = 5;
  localparam int unsigned RunCntW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxLimitEn = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMaxIn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxMaxOut  = 2'd2;

  // reset values of the limit registers
  localparam logic [LimitW-1:0] MaxInReset  = LimitW'(4096);
  localparam logic [LimitW-1:0] MaxOutReset = LimitW'(512);

  // configuration seen by the decoder
  typedef struct packed {
    logic              limit_en;
    logic [LimitW-1:0] max_in;
    logic [LimitW-1:0] max_out;
  } cfg_t;

  // output bytes caused by one input beat; nbytes of zero is a bare end marker
  typedef struct packed {
    logic [RunBytes-1:0][7:0] bytes;
    logic [RunCntW-1:0]       nbytes;
    logic                     text_end;
  } run_t;

endpackage

// ----- rtl/core/utnw_if.sv -----
// valid/ready channel interfaces for raw input bytes and normalized output
`timescale 1ns / 1ps

interface utnw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_last;

  modport source (output valid, output in_byte, output text_last, input ready);
  modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

interface utnw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       text_end;
  logic       run_last;

  modport source (output valid, output out_byte, output byte_valid, output text_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input text_end,
                input run_last, output ready);
endinterface

// ----- rtl/core/utnw_decoder.sv -----
// per-byte utf-8 decode, separator folding and limit tracking
`timescale 1ns / 1ps

module utnw_decoder import utnw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       beat_i,
  input  logic [7:0] in_byte_i,
  input  logic       text_last_i,
  output logic       push_o,
  output run_t       run_o
);

  // separator and control code points
  function automatic logic is_sep(input logic [20:0] c);
    is_sep = (c <= 21'h20) || (c >= 21'h7f && c <= 21'h9f) || (c == 21'ha0) ||
             (c == 21'h1680) || (c >= 21'h2000 && c <= 21'h200a) ||
             (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202f) ||
             (c == 21'h205f) || (c == 21'h3000);
  endfunction

  logic [7:0]      held_q [3];
  logic [7:0]      held_d [3];
  logic [20:0]     pc_q, pc_d;
  logic [2:0]      exp_q, exp_d;
  logic [1:0]      recv_q, recv_d;
  logic            sp_q, sp_d;
  logic            os_q, os_d;
  logic            stop_q, stop_d;
  logic [CntW-1:0] cc_q, cc_d;
  logic [CntW-1:0] bc_q, bc_d;

  logic            lead_go;
  logic            fin_req;
  logic [20:0]     fin_code;
  logic [2:0]      fin_len;
  logic [3:0][7:0] fin_seq;
  logic [20:0]     fin_min;
  logic            fin_bad;
  logic [CntW:0]   cc_sum;
  logic [20:0]     pc_shift;

  assign pc_shift = {pc_q[14:0], in_byte_i[5:0]};

  // next state and result run for one beat
  always_comb begin
    held_d   = held_q;
    pc_d     = pc_q;
    exp_d    = exp_q;
    recv_d   = recv_q;
    sp_d     = sp_q;
    os_d     = os_q;
    stop_d   = stop_q;
    cc_d     = cc_q;
    bc_d     = bc_q;
    lead_go  = 1'b0;
    fin_req  = 1'b0;
    fin_code = '0;
    fin_len  = 3'd1;
    fin_seq  = '0;
    fin_min  = '0;
    fin_bad  = 1'b0;
    cc_sum   = '0;
    run_o    = '0;

    if (beat_i && !stop_q) begin
      if (cfg_i.limit_en && (bc_q >= cfg_i.max_in)) begin
        stop_d = 1'b1;
        exp_d  = '0;
        recv_d = '0;
      end else begin
        bc_d = (bc_q == '1) ? bc_q : bc_q + CntW'(1);
        if (exp_q != 3'd0) begin
          if (in_byte_i[7:6] == 2'b10) begin
            // continuation byte
            pc_d = pc_shift;
            if ((3'(recv_q) + 3'd1 >= exp_q) || (recv_q == 2'd3)) begin
              fin_req    = 1'b1;
              fin_code   = pc_shift;
              fin_len    = exp_q;
              fin_seq[0] = held_q[0];
              fin_seq[1] = held_q[1];
              fin_seq[2] = held_q[2];
              fin_seq[2'(exp_q - 3'd1)] = in_byte_i;
              exp_d      = '0;
              recv_d     = '0;
            end else begin
              held_d[recv_q] = in_byte_i;
              recv_d         = recv_q + 2'd1;
            end
          end else begin
            // mismatch drops the open sequence and restarts as a lead
            exp_d   = '0;
            recv_d  = '0;
            sp_d    = os_q;
            lead_go = 1'b1;
          end
        end else begin
          lead_go = 1'b1;
        end

        // lead byte
        if (lead_go) begin
          if (!in_byte_i[7]) begin
            fin_req    = 1'b1;
            fin_code   = {13'd0, in_byte_i};
            fin_len    = 3'd1;
            fin_seq[0] = in_byte_i;
          end else if (in_byte_i >= 8'hc2 && in_byte_i <= 8'hdf) begin
            pc_d      = {16'd0, in_byte_i[4:0]};
            exp_d     = 3'd2;
            held_d[0] = in_byte_i;
            recv_d    = 2'd1;
          end else if (in_byte_i >= 8'he0 && in_byte_i <= 8'hef) begin
            pc_d      = {17'd0, in_byte_i[3:0]};
            exp_d     = 3'd3;
            held_d[0] = in_byte_i;
            recv_d    = 2'd1;
          end else if (in_byte_i >= 8'hf0 && in_byte_i <= 8'hf4) begin
            pc_d      = {18'd0, in_byte_i[2:0]};
            exp_d     = 3'd4;
            held_d[0] = in_byte_i;
            recv_d    = 2'd1;
          end else begin
            sp_d = os_q;
          end
        end
      end
    end

    // completed character: validate, drop U+FEFF, apply char limit, emit
    if (fin_req) begin
      case (fin_len)
        3'd2:    fin_min = 21'h80;
        3'd3:    fin_min = 21'h800;
        3'd4:    fin_min = 21'h10000;
        default: fin_min = 21'h0;
      endcase
      fin_bad = (fin_code < fin_min) || (fin_code > 21'h10ffff) ||
                (fin_code >= 21'hd800 && fin_code <= 21'hdfff) || is_sep(fin_code);
      cc_sum  = {1'b0, cc_q} + (sp_d ? (CntW+1)'(2) : (CntW+1)'(1));
      if (fin_bad) begin
        sp_d = os_q;
      end else if (fin_code != 21'hfeff) begin
        if (cfg_i.limit_en && (cc_sum > {1'b0, cfg_i.max_out})) begin
          stop_d = 1'b1;
          exp_d  = '0;
          recv_d = '0;
        end else begin
          if (sp_d) begin
            run_o.bytes  = {fin_seq, 8'h20};
            run_o.nbytes = fin_len + 3'd1;
          end else begin
            run_o.bytes  = {8'h00, fin_seq};
            run_o.nbytes = fin_len;
          end
          sp_d = 1'b0;
          os_d = 1'b1;
          cc_d = cc_sum[CntW] ? '1 : cc_sum[CntW-1:0];
        end
      end
    end

    // text end clears everything
    if (beat_i && text_last_i) begin
      run_o.text_end = 1'b1;
      pc_d   = '0;
      exp_d  = '0;
      recv_d = '0;
      sp_d   = 1'b0;
      os_d   = 1'b0;
      stop_d = 1'b0;
      cc_d   = '0;
      bc_d   = '0;
    end
  end

  assign push_o = beat_i && ((run_o.nbytes != '0) || text_last_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      exp_q  <= '0;
      recv_q <= '0;
      sp_q   <= 1'b0;
      os_q   <= 1'b0;
      stop_q <= 1'b0;
      cc_q   <= '0;
      bc_q   <= '0;
    end else begin
      pc_q   <= pc_d;
      exp_q  <= exp_d;
      recv_q <= recv_d;
      sp_q   <= sp_d;
      os_q   <= os_d;
      stop_q <= stop_d;
      cc_q   <= cc_d;
      bc_q   <= bc_d;
    end
  end

  // held bytes of the open sequence
  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ----- rtl/core/utnw_serializer.sv -----
// two-slot run buffer that sends one output byte per beat
`timescale 1ns / 1ps

module utnw_serializer import utnw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  run_t        run_i,
  output logic        ready_o,
  utnw_out_if.source  out_ch
);

  run_t               slot_q [2];
  run_t               slot_d [2];
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         cnt_mid;
  logic [RunCntW-1:0] idx_q, idx_d;
  logic               fire;
  logic               pop;

  // head run drives the output channel
  assign out_ch.valid      = (cnt_q != 2'd0);
  assign out_ch.out_byte   = slot_q[0].bytes[idx_q];
  assign out_ch.byte_valid = (slot_q[0].nbytes != '0);
  assign out_ch.run_last   = (slot_q[0].nbytes == '0) ||
                             (idx_q + RunCntW'(1) == slot_q[0].nbytes);
  assign out_ch.text_end   = out_ch.run_last && slot_q[0].text_end;

  assign ready_o = (cnt_q != 2'd2);
  assign fire    = out_ch.valid && out_ch.ready;
  assign pop     = fire && out_ch.run_last;

  // slot shift, push behind the remaining runs
  always_comb begin
    slot_d  = slot_q;
    cnt_mid = cnt_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_mid   = cnt_q - 2'd1;
    end
    cnt_d = cnt_mid;
    if (push_i) begin
      slot_d[cnt_mid[0]] = run_i;
      cnt_d              = cnt_mid + 2'd1;
    end
  end

  // byte index within the head run
  always_comb begin
    idx_d = idx_q;
    if (pop) begin
      idx_d = '0;
    end else if (fire) begin
      idx_d = idx_q + RunCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ----- rtl/core/utf8_text_whitespace_normalizer_unit.sv -----
// top level of the utf-8 text whitespace normalizer
// Usage: raw text bytes arrive one per beat on in_ch, text_last marking the
// final byte of a text. Each byte is decoded in the cycle it is accepted and
// yields zero to five output beats on out_ch: an optional 0x20 space and the
// bytes of a kept character. The beat that ends a text has text_end set; a
// text whose last byte yields nothing gets a bare end marker (byte_valid 0).
// run_last flags the last beat caused by one input byte.
// An accepted byte's run is registered into the run buffer; its first beat
// is offered once runs ahead of it are sent. Input accepts one byte per cycle
// unless in_ch.ready is low; out_ch sends one beat per cycle while ready is high.
// A two-run buffer between decoder and output keeps input flowing while a
// finished run waits; in_ch.ready drops only when both runs are occupied,
// which is how a stalled receiver pushes back on the sender.
// Configuration writes (limit_enable, max_input_bytes, max_output_chars) are
// taken at any edge with cfg_we_i high and must only happen while idle.
// Reset clears all text state and loads limit_enable 0, max_input_bytes 4096
// and max_output_chars 512; no clearing pass is needed.
`timescale 1ns / 1ps

module utf8_text_whitespace_normalizer_unit import utnw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  utnw_in_if.sink            in_ch,
  utnw_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic beat;
  logic push;
  run_t run;
  logic buf_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_en <= 1'b0;
      cfg_q.max_in   <= MaxInReset;
      cfg_q.max_out  <= MaxOutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxLimitEn: cfg_q.limit_en <= cfg_wdata_i[0];
        CfgIdxMaxIn:   cfg_q.max_in   <= cfg_wdata_i[LimitW-1:0];
        CfgIdxMaxOut:  cfg_q.max_out  <= cfg_wdata_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_ch.ready = buf_ready;
  assign beat        = in_ch.valid && buf_ready;

  utnw_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .beat_i      (beat),
    .in_byte_i   (in_ch.in_byte),
    .text_last_i (in_ch.text_last),
    .push_o      (push),
    .run_o       (run)
  );

  utnw_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run),
    .ready_o (buf_ready),
    .out_ch  (out_ch)
  );

endmodule
